FILE: design/rlpc_pkg.sv
// Package for the RGB LED pattern PWM controller: timing constants, register
// indexes, mode codes, colour table and the shared structs. No dependencies.
`default_nettype none

package rlpc_pkg;

    // PWM period and pattern timing (periods per step)
    localparam logic [4:0] PWM_STEPS         = 5'd20;
    localparam logic [7:0] FADE_STEP_PERIODS = 8'd250;
    localparam logic [7:0] COLOR_PERIODS     = 8'd240;
    localparam logic [7:0] STROBE_PERIODS    = 8'd60;
    localparam logic [4:0] HALF_LEVEL        = 5'd5;
    localparam logic [15:0] HOLD_MAX         = 16'hFFFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_SERIES = 2'd0;
    localparam logic [1:0] CFG_START  = 2'd1;
    localparam logic [1:0] CFG_STEP   = 2'd2;
    localparam logic [1:0] CFG_HALT   = 2'd3;

    // Series code for animated patterns; anything else is static colour
    localparam logic [1:0] SERIES_ANIM = 2'd2;

    // Mode codes
    localparam logic [2:0] MODE_SWEEP   = 3'd1;
    localparam logic [2:0] MODE_STROBE  = 3'd2;
    localparam logic [2:0] MODE_FADE_G  = 3'd3;
    localparam logic [2:0] MODE_FADE_R  = 3'd4;
    localparam logic [2:0] MODE_FADE_W  = 3'd5;
    localparam logic [2:0] MODE_RAINBOW = 3'd6;
    localparam logic [2:0] MODE_COUNT   = 3'd6;

    // Colour codes
    localparam logic [2:0] COLOUR_BLACK = 3'd0;

    typedef struct packed {
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
    } t_rgb;

    typedef struct packed {
        logic red;
        logic green;
        logic blue;
    } t_led;

    // Button decode results for one request
    typedef struct packed {
        logic       hit;        // mode step or sleep request this period
        logic       saved;
        logic       sleep;
        logic [2:0] mode_cur;   // mode before this request
        logic [2:0] mode_next;  // mode after this request
    } t_btn_status;

    // Out-of-range modes fall back to mode 1
    function automatic logic [2:0] clamp_mode(input logic [2:0] m);
        logic [2:0] res;
        res = MODE_SWEEP;
        if (m >= MODE_SWEEP && m <= MODE_COUNT) begin
            res = m;
        end
        return res;
    endfunction

    // Fixed colour table, levels in PWM slots
    function automatic t_rgb colour_levels(input logic [2:0] c);
        t_rgb res;
        res = '0;
        case (c)
            3'd1: begin
                res.red = PWM_STEPS; res.green = HALF_LEVEL; res.blue = HALF_LEVEL;
            end
            3'd2: begin
                res.green = HALF_LEVEL; res.blue = PWM_STEPS;
            end
            3'd3: begin
                res.red = PWM_STEPS; res.blue = PWM_STEPS;
            end
            3'd4: begin
                res.blue = PWM_STEPS;
            end
            3'd5: begin
                res.red = PWM_STEPS; res.green = PWM_STEPS; res.blue = PWM_STEPS;
            end
            3'd6: begin
                res.green = PWM_STEPS; res.blue = PWM_STEPS;
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/rlpc_button.sv
// Button press decoder: hold counter, release detect, mode register.
// Depends on rlpc_pkg.
`default_nettype none

module rlpc_button (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic                 i_slot_last,
    input  wire logic                 i_pressed,
    input  wire logic [15:0]          i_step_periods,
    input  wire logic [15:0]          i_halt_periods,
    input  wire logic                 i_mode_load,
    input  wire logic [2:0]           i_mode_load_value,
    output rlpc_pkg::t_btn_status     o_status
);

    logic [15:0] r_hold;
    logic [15:0] n_hold;
    logic        r_last_pressed;
    logic        n_last_pressed;
    logic [2:0]  r_mode;
    logic [2:0]  n_mode;
    logic        hit;
    logic        saved;
    logic        sleep;

    // Sample on the last slot of a period; act on two released samples in a row
    always_comb begin
        n_hold         = r_hold;
        n_last_pressed = r_last_pressed;
        n_mode         = r_mode;
        hit            = 1'b0;
        saved          = 1'b0;
        sleep          = 1'b0;
        if (i_fire && i_slot_last) begin
            if (i_pressed && r_hold != rlpc_pkg::HOLD_MAX) begin
                n_hold = r_hold + 16'd1;
            end
            if (!i_pressed && !r_last_pressed) begin
                if (r_hold > i_halt_periods) begin
                    sleep = 1'b1;
                    hit   = 1'b1;
                end else if (r_hold > i_step_periods) begin
                    n_mode = (r_mode >= rlpc_pkg::MODE_COUNT) ? rlpc_pkg::MODE_SWEEP
                                                               : r_mode + 3'd1;
                    saved  = 1'b1;
                    hit    = 1'b1;
                end
                n_hold = '0;
            end
            n_last_pressed = i_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold         <= '0;
            r_last_pressed <= 1'b0;
            r_mode         <= rlpc_pkg::MODE_SWEEP;
        end else begin
            r_hold         <= n_hold;
            r_last_pressed <= n_last_pressed;
            if (i_mode_load) begin
                r_mode <= rlpc_pkg::clamp_mode(i_mode_load_value);
            end else begin
                r_mode <= n_mode;
            end
        end
    end

    assign o_status.hit       = hit;
    assign o_status.saved     = saved;
    assign o_status.sleep     = sleep;
    assign o_status.mode_cur  = r_mode;
    assign o_status.mode_next = n_mode;

endmodule

`default_nettype wire

FILE: design/rlpc_pattern.sv
// Pattern sequencer and PWM compare: slot counter, pattern latch, sweep,
// strobe and fade counters, LED levels. Depends on rlpc_pkg.
`default_nettype none

module rlpc_pattern (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [1:0]           i_series,
    input  wire rlpc_pkg::t_btn_status i_btn,
    output logic                      o_slot_last,
    output rlpc_pkg::t_led            o_led
);

    logic [4:0] r_slot;
    logic [7:0] r_period;
    logic [7:0] n_period;
    logic [4:0] r_ramp;
    logic [4:0] n_ramp;
    logic [2:0] r_seg;
    logic [2:0] n_seg;
    logic       r_dark;
    logic       n_dark;
    logic       r_anim;
    logic       n_anim;
    logic [2:0] r_run_mode;
    logic [2:0] n_run_mode;
    logic       r_done;
    logic       n_done;

    logic       latch;
    logic [4:0] lvl_v;
    logic [4:0] lvl_d;
    logic [2:0] phases;
    logic [7:0] seg_len;
    rlpc_pkg::t_rgb lvl;

    assign o_slot_last = (r_slot == rlpc_pkg::PWM_STEPS - 5'd1);
    assign latch       = (r_slot == 5'd0) && r_done;

    // Pattern state seen by this slot; fresh latch at period start after r_done
    always_comb begin
        if (latch) begin
            n_anim     = (i_series == rlpc_pkg::SERIES_ANIM);
            n_run_mode = i_btn.mode_cur;
            n_period   = '0;
            n_ramp     = '0;
            n_seg      = '0;
            n_dark     = 1'b0;
            n_done     = 1'b0;
        end else begin
            n_anim     = r_anim;
            n_run_mode = r_run_mode;
            n_period   = r_period;
            n_ramp     = r_ramp;
            n_seg      = r_seg;
            n_dark     = r_dark;
            n_done     = r_done;
        end
    end

    // Ramp level and its complement
    assign lvl_v = (n_ramp >= rlpc_pkg::PWM_STEPS - 5'd1) ? rlpc_pkg::PWM_STEPS
                                                           : n_ramp + 5'd1;
    assign lvl_d = rlpc_pkg::PWM_STEPS - lvl_v;

    // Channel levels for this period
    always_comb begin
        lvl = '0;
        if (!n_anim) begin
            lvl = rlpc_pkg::colour_levels(i_btn.mode_cur);
        end else if (n_run_mode == rlpc_pkg::MODE_SWEEP) begin
            lvl = rlpc_pkg::colour_levels(n_seg + 3'd1);
        end else if (n_run_mode == rlpc_pkg::MODE_STROBE) begin
            lvl = rlpc_pkg::colour_levels(n_dark ? rlpc_pkg::COLOUR_BLACK : n_seg + 3'd1);
        end else begin
            lvl.blue = rlpc_pkg::PWM_STEPS;
            case (n_run_mode)
                rlpc_pkg::MODE_FADE_G: begin
                    lvl.red   = '0;
                    lvl.green = (n_seg != 3'd0) ? lvl_d : lvl_v;
                end
                rlpc_pkg::MODE_FADE_R: begin
                    lvl.red   = (n_seg != 3'd0) ? lvl_d : lvl_v;
                    lvl.green = '0;
                end
                rlpc_pkg::MODE_FADE_W: begin
                    lvl.red   = rlpc_pkg::PWM_STEPS;
                    lvl.green = (n_seg != 3'd0) ? lvl_d : lvl_v;
                end
                default: begin
                    case (n_seg)
                        3'd0: begin
                            lvl.red = '0;                  lvl.green = lvl_v;
                        end
                        3'd1: begin
                            lvl.red = lvl_v;               lvl.green = rlpc_pkg::PWM_STEPS;
                        end
                        3'd2: begin
                            lvl.red = rlpc_pkg::PWM_STEPS; lvl.green = lvl_d;
                        end
                        default: begin
                            lvl.red = lvl_d;               lvl.green = '0;
                        end
                    endcase
                end
            endcase
        end
    end

    // PWM compare
    assign o_led.red   = (r_slot < lvl.red);
    assign o_led.green = (r_slot < lvl.green);
    assign o_led.blue  = (r_slot < lvl.blue);

    assign phases  = (n_run_mode == rlpc_pkg::MODE_RAINBOW) ? 3'd4 : 3'd2;
    assign seg_len = (n_run_mode == rlpc_pkg::MODE_SWEEP) ? rlpc_pkg::COLOR_PERIODS
                                                          : rlpc_pkg::STROBE_PERIODS;

    // State update; pattern advances once per period on the last slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_period   <= '0;
            r_ramp     <= '0;
            r_seg      <= '0;
            r_dark     <= 1'b0;
            r_anim     <= 1'b0;
            r_run_mode <= rlpc_pkg::MODE_SWEEP;
            r_done     <= 1'b1;
        end else if (i_fire) begin
            r_anim     <= n_anim;
            r_run_mode <= n_run_mode;
            r_period   <= n_period;
            r_ramp     <= n_ramp;
            r_seg      <= n_seg;
            r_dark     <= n_dark;
            r_done     <= n_done;
            if (!o_slot_last) begin
                r_slot <= r_slot + 5'd1;
            end else begin
                r_slot <= '0;
                if (!n_anim) begin
                    r_done <= 1'b1;
                end else if (n_run_mode == rlpc_pkg::MODE_SWEEP ||
                             n_run_mode == rlpc_pkg::MODE_STROBE) begin
                    // sweep / strobe: a button hit only cuts the segment short
                    if (i_btn.hit || (n_period + 8'd1 >= seg_len)) begin
                        r_period <= '0;
                        if (n_run_mode == rlpc_pkg::MODE_STROBE && !n_dark) begin
                            r_dark <= 1'b1;
                        end else begin
                            r_dark <= 1'b0;
                            r_seg  <= n_seg + 3'd1;
                            if (n_seg + 3'd1 >= rlpc_pkg::MODE_COUNT) begin
                                r_done <= 1'b1;
                            end
                        end
                    end else begin
                        r_period <= n_period + 8'd1;
                    end
                end else if (i_btn.hit) begin
                    // fades abort at once
                    r_done <= 1'b1;
                end else if (n_period + 8'd1 < rlpc_pkg::FADE_STEP_PERIODS) begin
                    r_period <= n_period + 8'd1;
                end else begin
                    r_period <= '0;
                    if (n_ramp + 5'd1 < rlpc_pkg::PWM_STEPS) begin
                        r_ramp <= n_ramp + 5'd1;
                    end else begin
                        r_ramp <= '0;
                        r_seg  <= n_seg + 3'd1;
                        if (n_seg + 3'd1 >= phases) begin
                            r_done <= 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/rgb_led_pattern_pwm_controller_top.sv
// Top level of the RGB LED pattern PWM controller: request and result
// registers, configuration registers. Depends on rlpc_pkg, rlpc_button, rlpc_pattern.
// Latency: 2 register stages, the request register then the result register.
// Throughput: one request (one PWM slot) per cycle while the result channel is not
// stalled, limited by the single request/result register pair around the slot logic.
// Reset: synchronous active low; config returns to series 1, mode 1,
// thresholds 20 and 4000; counters clear, a new pattern latches at slot 0.
`default_nettype none

module rgb_led_pattern_pwm_controller_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_button_pressed,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_led_red,
    output logic             o_led_green,
    output logic             o_led_blue,
    output logic [2:0]       o_current_mode,
    output logic             o_mode_saved,
    output logic             o_sleep_request,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata
);

    logic        r_in_valid;
    logic        r_in_button;
    logic        r_out_valid;
    logic        r_led_red;
    logic        r_led_green;
    logic        r_led_blue;
    logic [2:0]  r_mode;
    logic        r_saved;
    logic        r_sleep;
    logic [1:0]  r_cfg_series;
    logic [15:0] r_cfg_step;
    logic [15:0] r_cfg_halt;

    logic        out_free;
    logic        fire;
    logic        slot_last;
    logic        mode_load;
    rlpc_pkg::t_btn_status btn;
    rlpc_pkg::t_led        led;

    // Pipeline control: slot logic fires when a request is held and the result register can take it
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign mode_load  = i_cfg_wr_en && (i_cfg_index == rlpc_pkg::CFG_START);

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_button <= i_button_pressed;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_series <= 2'd1;
            r_cfg_step   <= 16'd20;
            r_cfg_halt   <= 16'd4000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rlpc_pkg::CFG_SERIES: r_cfg_series <= i_cfg_wdata[1:0];
                rlpc_pkg::CFG_STEP:   r_cfg_step   <= i_cfg_wdata;
                rlpc_pkg::CFG_HALT:   r_cfg_halt   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rlpc_button u_button (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_slot_last       (slot_last),
        .i_pressed         (r_in_button),
        .i_step_periods    (r_cfg_step),
        .i_halt_periods    (r_cfg_halt),
        .i_mode_load       (mode_load),
        .i_mode_load_value (i_cfg_wdata[2:0]),
        .o_status          (btn)
    );

    rlpc_pattern u_pattern (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_series    (r_cfg_series),
        .i_btn       (btn),
        .o_slot_last (slot_last),
        .o_led       (led)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_led_red   <= led.red;
            r_led_green <= led.green;
            r_led_blue  <= led.blue;
            r_mode      <= btn.mode_next;
            r_saved     <= btn.saved;
            r_sleep     <= btn.sleep;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_led_red       = r_led_red;
    assign o_led_green     = r_led_green;
    assign o_led_blue      = r_led_blue;
    assign o_current_mode  = r_mode;
    assign o_mode_saved    = r_saved;
    assign o_sleep_request = r_sleep;

endmodule

`default_nettype wire
